// File: sv/scd_pkg.sv
// shared types, constants and tables for the seconds-counter-to-date converter
`default_nettype none

package scd_pkg;

    // configuration port
    localparam int ADDR_W = 3;
    localparam int EPOCH_W = 22;
    localparam logic [0:0] REG_EPOCH = 1'b0;
    localparam logic [EPOCH_W-1:0] EPOCH_RESET = 22'd2440588;

    // calendar constants
    localparam int unsigned SECS_PER_DAY = 86400;
    localparam int unsigned SECS_PER_MIN = 60;
    localparam int unsigned DAYS_PER_WEEK = 7;
    localparam int unsigned JDN_SHIFT = 32044;
    localparam int unsigned DAYS_PER_400Y = 146097;
    localparam int unsigned DAYS_PER_4Y = 1461;
    localparam int unsigned MONTH_SPAN = 153;
    localparam int unsigned YEAR_SHIFT = 4800;

    // reciprocals floor(2^s / d); the shift is at least the dividend width
    localparam int unsigned RECIP_DAY = 49710;   // s = 32
    localparam int unsigned RECIP_MIN_S = 2184;  // s = 17
    localparam int unsigned RECIP_MIN_M = 34;    // s = 11
    localparam int unsigned RECIP_WEEK = 9362;   // s = 16
    localparam int unsigned RECIP_400Y = 229;    // s = 25
    localparam int unsigned RECIP_4Y = 179;      // s = 18
    localparam int unsigned RECIP_MSPAN = 13;    // s = 11

    // first field in the highest bits, year in the lowest bits
    typedef struct packed {
        logic [2:0]  weekday;
        logic [5:0]  second;
        logic [5:0]  minute;
        logic [4:0]  hour;
        logic [4:0]  day_of_month;
        logic [3:0]  month;
        logic [11:0] year;
    } result_t;

    // days before the start of month index m, year starting in march
    function automatic logic [8:0] month_start(input logic [3:0] m);
        logic [8:0] v;
        case (m)
            4'd0:    v = 9'd0;
            4'd1:    v = 9'd31;
            4'd2:    v = 9'd61;
            4'd3:    v = 9'd92;
            4'd4:    v = 9'd122;
            4'd5:    v = 9'd153;
            4'd6:    v = 9'd184;
            4'd7:    v = 9'd214;
            4'd8:    v = 9'd245;
            4'd9:    v = 9'd275;
            4'd10:   v = 9'd306;
            4'd11:   v = 9'd337;
            default: v = 9'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// File: sv/scd_cdiv.sv
// three-stage divider by a constant: reciprocal multiply, remainder, one correction
`default_nettype none

module scd_cdiv #(
    parameter int XW = 32,
    parameter int QW = 16,
    parameter int SW = 1,
    parameter int unsigned D = 86400,
    parameter int unsigned M = 49710,
    parameter int S = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  logic                   in_valid,
    input  logic [XW-1:0]          x,
    input  logic [SW-1:0]          side_in,
    output logic                   out_valid,
    output logic [QW-1:0]          q,
    output logic [$clog2(D)-1:0]   rem,
    output logic [SW-1:0]          side_out
);

    localparam int RW = $clog2(D);
    localparam int MW = $clog2(M + 1);
    localparam int PW = XW + MW;
    localparam logic [PW-1:0] M_P = PW'(M);
    localparam logic [PW-1:0] D_P = PW'(D);
    localparam logic [RW:0] D_R = (RW + 1)'(D);

    logic          s1_valid_reg;
    logic [XW-1:0] s1_x_reg;
    logic [QW-1:0] s1_q_reg;
    logic [SW-1:0] s1_side_reg;
    logic          s2_valid_reg;
    logic [QW-1:0] s2_q_reg;
    logic [RW:0]   s2_rem_reg;
    logic [SW-1:0] s2_side_reg;
    logic          s3_valid_reg;
    logic [QW-1:0] s3_q_reg;
    logic [RW-1:0] s3_rem_reg;
    logic [SW-1:0] s3_side_reg;

    logic [PW-1:0] prod;
    logic [PW-1:0] prod_shift;
    logic [QW-1:0] s1_q_next;
    logic [PW-1:0] diff;
    logic [RW:0]   s2_rem_next;
    logic          over;
    logic [QW-1:0] s3_q_next;
    logic [RW:0]   s3_rem_next;

    // estimate is the true quotient or one below it
    assign prod       = PW'(x) * M_P;
    assign prod_shift = prod >> S;
    assign s1_q_next  = prod_shift[QW-1:0];

    assign diff        = PW'(s1_x_reg) - PW'(s1_q_reg) * D_P;
    assign s2_rem_next = diff[RW:0];

    assign over        = (s2_rem_reg >= D_R);
    assign s3_q_next   = over ? s2_q_reg + QW'(1) : s2_q_reg;
    assign s3_rem_next = over ? s2_rem_reg - D_R : s2_rem_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_x_reg    <= x;
            s1_q_reg    <= s1_q_next;
            s1_side_reg <= side_in;
            s2_q_reg    <= s1_q_reg;
            s2_rem_reg  <= s2_rem_next;
            s2_side_reg <= s1_side_reg;
            s3_q_reg    <= s3_q_next;
            s3_rem_reg  <= s3_rem_next[RW-1:0];
            s3_side_reg <= s2_side_reg;
        end
    end

    assign out_valid = s3_valid_reg;
    assign q         = s3_q_reg;
    assign rem       = s3_rem_reg;
    assign side_out  = s3_side_reg;

endmodule

`default_nettype wire

// File: sv/scd_skid.sv
// output register with a skid entry so the pipeline stall is registered
`default_nettype none

module scd_skid (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  scd_pkg::result_t in_data,
    output logic             ready,
    output logic             out_valid,
    output scd_pkg::result_t out_data,
    input  logic             out_ready
);

    import scd_pkg::*;

    logic    out_valid_reg;
    result_t out_data_reg;
    logic    sk_valid_reg;
    result_t sk_data_reg;
    logic    hold;

    assign hold = out_valid_reg && !out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            sk_valid_reg  <= 1'b0;
        end
        else if (hold)
        begin
            if (in_valid && !sk_valid_reg)
            begin
                sk_valid_reg <= 1'b1;
            end
        end
        else if (sk_valid_reg)
        begin
            out_valid_reg <= 1'b1;
            sk_valid_reg  <= 1'b0;
        end
        else
        begin
            out_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (hold)
        begin
            if (in_valid && !sk_valid_reg)
            begin
                sk_data_reg <= in_data;
            end
        end
        else if (sk_valid_reg)
        begin
            out_data_reg <= sk_data_reg;
        end
        else
        begin
            out_data_reg <= in_data;
        end
    end

    assign ready     = !sk_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

// File: sv/seconds_counter_to_date.sv
// throughput: one request per cycle; the pipeline holds only while the skid entry is full
// the path is seven constant dividers of three stages each plus the output register
// reset: pipeline and output empty, epoch_day_number back to 2440588 (1970-01-01)
// top level: seconds counter to gregorian date and time, with config register
`default_nettype none

module seconds_counter_to_date (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [31:0]                 s_tdata,   // [31:0] seconds_count
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // [11:0] year, [15:12] month, [20:16] day_of_month, [25:21] hour,
    // [31:26] minute, [37:32] second, [40:38] weekday, [47:41] zero
    output logic [47:0]                 m_tdata,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [scd_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    import scd_pkg::*;

    logic [EPOCH_W-1:0] epoch_reg;
    logic [EPOCH_W-1:0] epoch_next;
    logic [0:0]         reg_index;
    logic               cfg_write;
    logic               en;

    // configuration
    assign reg_index  = paddr[ADDR_W-1:2];
    assign cfg_write  = psel && penable && pwrite && (reg_index == REG_EPOCH);
    assign epoch_next = cfg_write ? pwdata[EPOCH_W-1:0] : epoch_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            epoch_reg <= EPOCH_RESET;
        end
        else
        begin
            epoch_reg <= epoch_next;
        end
    end

    assign prdata = (reg_index == REG_EPOCH) ? {{(32 - EPOCH_W){1'b0}}, epoch_reg} : 32'd0;
    assign pready = 1'b1;

    // seconds into whole days and seconds of day
    logic        u1_valid;
    logic [15:0] u1_days;
    logic [16:0] u1_secs;

    scd_cdiv #(.XW(32), .QW(16), .SW(1), .D(SECS_PER_DAY), .M(RECIP_DAY), .S(32)) u_day (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_valid(s_tvalid), .x(s_tdata), .side_in(1'b0),
        .out_valid(u1_valid), .q(u1_days), .rem(u1_secs), .side_out()
    );

    // seconds of day into minutes of day and second
    logic        t1_valid;
    logic [10:0] t1_mins;
    logic [5:0]  t1_sec;
    logic [15:0] t1_days;

    scd_cdiv #(.XW(17), .QW(11), .SW(16), .D(SECS_PER_MIN), .M(RECIP_MIN_S), .S(17)) u_sec (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_valid(u1_valid), .x(u1_secs), .side_in(u1_days),
        .out_valid(t1_valid), .q(t1_mins), .rem(t1_sec), .side_out(t1_days)
    );

    // minutes of day into hour and minute
    logic        t2_valid;
    logic [4:0]  t2_hour;
    logic [5:0]  t2_minute;
    logic [21:0] t2_side;

    scd_cdiv #(.XW(11), .QW(5), .SW(22), .D(SECS_PER_MIN), .M(RECIP_MIN_M), .S(11)) u_min (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_valid(t1_valid), .x(t1_mins), .side_in({t1_sec, t1_days}),
        .out_valid(t2_valid), .q(t2_hour), .rem(t2_minute), .side_out(t2_side)
    );

    // weekday from days plus one
    logic        t3_valid;
    logic [2:0]  t3_wk;
    logic [32:0] t3_side;
    logic [15:0] t3_x;
    logic [4:0]  t3_hour;
    logic [5:0]  t3_minute;
    logic [5:0]  t3_sec;
    logic [15:0] t3_days;

    assign t3_x = t2_side[15:0] + 16'd1;

    scd_cdiv #(.XW(16), .QW(13), .SW(33), .D(DAYS_PER_WEEK), .M(RECIP_WEEK), .S(16)) u_week (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_valid(t2_valid), .x(t3_x), .side_in({t2_hour, t2_minute, t2_side}),
        .out_valid(t3_valid), .q(), .rem(t3_wk), .side_out(t3_side)
    );

    assign {t3_hour, t3_minute, t3_sec, t3_days} = t3_side;

    // shifted day number into 400-year cycles
    logic [22:0] jdn_a;
    logic [24:0] u2_x;
    logic        u2_valid;
    logic [6:0]  u2_cent;
    logic [17:0] u2_rem;
    logic [19:0] u2_side;

    assign jdn_a = 23'(t3_days) + 23'(JDN_SHIFT) + 23'(epoch_reg);
    assign u2_x  = {jdn_a, 2'b11};

    scd_cdiv #(.XW(25), .QW(7), .SW(20), .D(DAYS_PER_400Y), .M(RECIP_400Y), .S(25)) u_cent (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_valid(t3_valid), .x(u2_x), .side_in({t3_hour, t3_minute, t3_sec, t3_wk}),
        .out_valid(u2_valid), .q(u2_cent), .rem(u2_rem), .side_out(u2_side)
    );

    // 4*r+3 equals the remainder plus the low two bits of the cycle count
    logic [17:0] u3_x;
    logic        u3_valid;
    logic [6:0]  u3_yr;
    logic [10:0] u3_rem;
    logic [26:0] u3_side;

    assign u3_x = u2_rem + 18'(u2_cent[1:0]);

    scd_cdiv #(.XW(18), .QW(7), .SW(27), .D(DAYS_PER_4Y), .M(RECIP_4Y), .S(18)) u_year (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_valid(u2_valid), .x(u3_x), .side_in({u2_cent, u2_side}),
        .out_valid(u3_valid), .q(u3_yr), .rem(u3_rem), .side_out(u3_side)
    );

    // day of year from the remainder, then 5*e+2 for the month split
    logic [10:0] e_sum;
    logic [8:0]  e_day;
    logic [10:0] u4_x;
    logic        u4_valid;
    logic [3:0]  u4_m;
    logic [42:0] u4_side;

    assign e_sum = u3_rem + 11'(u3_yr[1:0]) - 11'd3;
    assign e_day = e_sum[10:2];
    assign u4_x  = {e_day, 2'b00} + 11'(e_day) + 11'd2;

    scd_cdiv #(.XW(11), .QW(4), .SW(43), .D(MONTH_SPAN), .M(RECIP_MSPAN), .S(11)) u_month (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_valid(u3_valid), .x(u4_x), .side_in({e_day, u3_yr, u3_side}),
        .out_valid(u4_valid), .q(u4_m), .rem(), .side_out(u4_side)
    );

    // final field assembly
    logic [8:0]  f_e;
    logic [6:0]  f_yr;
    logic [6:0]  f_cent;
    logic [4:0]  f_hour;
    logic [5:0]  f_minute;
    logic [5:0]  f_sec;
    logic [2:0]  f_wk;
    logic        late;
    logic [13:0] cent_years;
    logic [8:0]  mday_full;
    result_t     res;
    result_t     out_res;

    assign {f_e, f_yr, f_cent, f_hour, f_minute, f_sec, f_wk} = u4_side;

    // january and february belong to the next calendar year
    assign late       = (u4_m >= 4'd10);
    assign cent_years = 14'(f_cent) * 14'd100;
    assign mday_full  = f_e - month_start(u4_m) + 9'd1;

    always_comb
    begin
        res.year         = cent_years[11:0] + 12'(f_yr) + 12'(late) - 12'(YEAR_SHIFT);
        res.month        = late ? u4_m - 4'd9 : u4_m + 4'd3;
        res.day_of_month = mday_full[4:0];
        res.hour         = f_hour;
        res.minute       = f_minute;
        res.second       = f_sec;
        res.weekday      = f_wk;
    end

    scd_skid u_skid (
        .clk(clk), .rst_n(rst_n),
        .in_valid(u4_valid), .in_data(res), .ready(en),
        .out_valid(m_tvalid), .out_data(out_res), .out_ready(m_tready)
    );

    assign s_tready = en;
    assign m_tdata  = {7'd0, out_res};

endmodule

`default_nettype wire

// File: sv/scd_checker.sv
// port-level checks for the seconds-counter-to-date converter, bound to the top level
`default_nettype none

module scd_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        s_tready,
    input logic                        m_tvalid,
    input logic                        m_tready,
    input logic [47:0]                 m_tdata,
    input logic                        psel,
    input logic                        penable,
    input logic                        pwrite,
    input logic [scd_pkg::ADDR_W-1:0]  paddr,
    input logic [31:0]                 pwdata,
    input logic [31:0]                 prdata,
    input logic                        pready
);

    import scd_pkg::*;

    // a result waiting on the output must not vanish
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result changed while stalled");

    // result fields within their calendar range; the year is not checked, the day of month only from below
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[15:12] >= 4'd1) && (m_tdata[15:12] <= 4'd12)
            && (m_tdata[20:16] >= 5'd1) && (m_tdata[25:21] <= 5'd23)
            && (m_tdata[31:26] <= 6'd59) && (m_tdata[37:32] <= 6'd59)
            && (m_tdata[40:38] <= 3'd6) && (m_tdata[47:41] == 7'd0))
        else $error("result field out of range");

    // input blocked only while a result is held on the output
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid)
        else $error("input stalled with empty output");

    // register reads back what was written
    assert property (@(posedge clk) disable iff (!rst_n)
        psel && penable && pwrite && pready && (paddr[2] == REG_EPOCH)
        |=> (paddr[2] != REG_EPOCH) || (prdata == {10'd0, $past(pwdata[21:0])}))
        else $error("epoch register readback mismatch");

endmodule

bind seconds_counter_to_date scd_checker u_scd_checker (
    .clk(clk), .rst_n(rst_n),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
);

`default_nettype wire
